// ----- hw/rtl/bcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bcs_pkg;
   localparam int BUDGET_W         = 12;
   localparam int HANDLE_W         = 32;
   localparam int LEN_W            = 12;
   localparam int PICK_LEN_W       = 7;
   localparam int PCT_W            = 7;
   localparam int NUM_W            = 19;
   localparam int DEF_MAX_SIZE     = 64;
   localparam int DEF_BUCKET_DEPTH = 2048;
   localparam int RESET_BUDGET     = 1500;
   localparam int PCT_SCALE        = 100;
   localparam int WIDEN_BELOW      = 75;
   localparam int TIGHTEN_ABOVE    = 98;

   typedef enum logic [1:0] {
      KIND_OFFER = 2'd0,
      KIND_PICK  = 2'd1,
      KIND_DONE  = 2'd2
   } bcs_kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_OFF_RD,
      S_OFF_CHK,
      S_WALK,
      S_FILL,
      S_DIV,
      S_RD,
      S_PICK,
      S_PCT
   } bcs_state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/bcs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcs_div #(
   parameter int NW = 18,
   parameter int DW = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic [NW-1:0]      quo
);
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= den;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/budgeted_clause_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Clause selector under a literal budget. Offered clause handles are kept in one bucket
// per size in a block memory, fill counts in a small second memory. After reset the
// fill memory is cleared, one entry a cycle; no word is taken meanwhile but budget
// writes are. Each accepted word gives exactly one response word. An offer reads the
// fill count, then checks it and writes it back. A pull that still has clauses pending
// at the current size reads the store, then emits. A pull that has to move on walks
// the sizes, reading each bucket's fill count; a bucket that does not fit whole goes
// through the serial divider, and the closing word of the round waits on the percent
// division. Budget writes are ignored during a round.
module budgeted_clause_selector
   import bcs_pkg::*;
#(
   parameter int MAX_SIZE     = DEF_MAX_SIZE,
   parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [HANDLE_W-1:0]   req_clause_handle,
   input  wire logic [LEN_W-1:0]      req_clause_len,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_accepted,
   output logic [HANDLE_W-1:0]        rsp_picked_handle,
   output logic [PICK_LEN_W-1:0]      rsp_picked_len,
   output logic [PCT_W-1:0]           rsp_percent_used,
   output logic                       rsp_widen_limit,
   output logic                       rsp_tighten_limit,
   input  wire logic                  csr_wr_en,
   input  wire logic [BUDGET_W-1:0]   csr_wr_data
);
   localparam int IXW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;   // bucket index
   localparam int SZW = $clog2(MAX_SIZE + 1);                    // size cursor
   localparam int FW  = $clog2(BUCKET_DEPTH + 1);                // fill count
   localparam int PW  = $clog2(BUCKET_DEPTH);                    // slot in bucket
   localparam int AW  = IXW + PW;
   localparam int OPW = LEN_W + FW + 1;                          // offer product
   localparam int CPW = FW + SZW + BUDGET_W;                     // fit compare
   localparam int MPW = BUDGET_W + SZW;                          // partial take product

   bcs_state_type state_ff, state_in;

   // control and walk state
   logic [IXW-1:0]      clr_ff, clr_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic                selecting_ff, selecting_in;
   logic [SZW-1:0]      cursor_ff, cursor_in;
   logic [BUDGET_W-1:0] space_ff, space_in;
   logic [FW-1:0]       take_ff, take_in;
   logic                whole_ff, whole_in;
   logic [FW-1:0]       rpos_ff, rpos_in;
   logic [FW-1:0]       cnt_ff, cnt_in;

   // latched request word
   logic                act_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [LEN_W-1:0]    len_ff;
   logic                off_ok_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   bcs_kind_type        kind_ff, kind_in;
   logic                acc_ff, acc_in;
   logic [HANDLE_W-1:0] phandle_ff, phandle_in;
   logic [PICK_LEN_W-1:0] plen_ff, plen_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic                widen_ff, widen_in;
   logic                tight_ff, tight_in;

   // memories
   logic [FW-1:0]       fill_mem [MAX_SIZE];
   logic [FW-1:0]       fill_rd_ff;
   logic                fill_re, fill_we;
   logic [IXW-1:0]      fill_raddr, fill_waddr;
   logic [FW-1:0]       fill_wdata;
   logic [HANDLE_W-1:0] store_mem [MAX_SIZE * (2 ** PW)];
   logic [HANDLE_W-1:0] store_rd_ff;
   logic                store_re, store_we;
   logic [AW-1:0]       store_raddr, store_waddr;

   // divider
   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [BUDGET_W-1:0] div_den;
   logic                div_busy;
   logic [NUM_W-1:0]    div_quo;

   // datapath helpers
   logic                accept;
   logic                out_free;
   logic                emit;
   logic [LEN_W-1:0]    len_m1;
   logic [SZW-1:0]      cur_m1;
   logic [SZW:0]        cur_p1;
   logic                walk_stop;
   logic [OPW-1:0]      off_prod;
   logic                off_ok;
   logic [FW+SZW-1:0]   bucket_lits;
   logic                bucket_fits;
   logic [MPW-1:0]      part_lits;
   logic [NUM_W-1:0]    pct_num;
   logic [PCT_W-1:0]    pct_q;
   logic [SZW+PICK_LEN_W-1:0] cur_wide;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign len_m1   = len_ff - 1'b1;
   assign cur_m1   = cursor_ff - 1'b1;
   assign cur_p1   = {1'b0, cursor_ff} + 1'b1;
   // round ends past the largest size or once not even one clause of the next size fits
   assign walk_stop = (cursor_ff >= SZW'(MAX_SIZE)) ||
                      ({1'b0, space_ff} < 13'(cur_p1));
   assign off_prod  = OPW'(len_ff) * OPW'({1'b0, fill_rd_ff} + 1'b1);
   assign off_ok    = off_ok_ff && (fill_rd_ff < FW'(BUCKET_DEPTH)) &&
                      (off_prod <= OPW'(budget_ff));
   assign bucket_lits = (FW+SZW)'(fill_rd_ff) * (FW+SZW)'(cursor_ff);
   assign bucket_fits = CPW'(bucket_lits) <= CPW'(space_ff);
   assign part_lits   = MPW'(div_quo[BUDGET_W-1:0]) * MPW'(cursor_ff);
   assign pct_num     = NUM_W'(budget_ff - space_ff) * NUM_W'(PCT_SCALE);
   assign pct_q       = div_quo[PCT_W-1:0];
   assign cur_wide    = (SZW+PICK_LEN_W)'(cursor_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (clr_ff == IXW'(MAX_SIZE - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (!req_action) state_in = S_OFF_RD;
               else if (selecting_ff && take_ff != '0) state_in = S_RD;
               else state_in = S_WALK;
            end
         end
         S_OFF_RD:  state_in = S_OFF_CHK;
         S_OFF_CHK: if (out_free) state_in = S_IDLE;
         S_WALK:    state_in = walk_stop ? S_PCT : S_FILL;
         S_FILL: begin
            if (!bucket_fits) state_in = S_DIV;
            else if (fill_rd_ff == '0) state_in = S_WALK;
            else state_in = S_RD;
         end
         S_DIV:     if (!div_busy) state_in = S_RD;
         S_RD:      state_in = S_PICK;
         S_PICK:    if (out_free) state_in = S_IDLE;
         S_PCT:     if (!div_busy && out_free) state_in = S_IDLE;
         default:   state_in = S_CLEAR;
      endcase
   end

   // memory, divider and handshake controls
   always_comb begin
      req_stall   = 1'b1;
      emit        = 1'b0;
      fill_re     = 1'b0;
      fill_raddr  = len_m1[IXW-1:0];
      fill_we     = 1'b0;
      fill_waddr  = cur_m1[IXW-1:0];
      fill_wdata  = '0;
      store_re    = 1'b0;
      store_raddr = {cur_m1[IXW-1:0], rpos_ff[PW-1:0]};
      store_we    = 1'b0;
      store_waddr = {len_m1[IXW-1:0], fill_rd_ff[PW-1:0]};
      div_start   = 1'b0;
      div_num     = NUM_W'(space_ff);
      div_den     = BUDGET_W'(cursor_ff);
      unique case (state_ff)
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
         end
         S_IDLE:   req_stall = 1'b0;
         S_OFF_RD: fill_re = 1'b1;
         S_OFF_CHK: begin
            if (out_free) begin
               emit = 1'b1;
               if (off_ok) begin
                  store_we   = 1'b1;
                  fill_we    = 1'b1;
                  fill_waddr = len_m1[IXW-1:0];
                  fill_wdata = fill_rd_ff + 1'b1;
               end
            end
         end
         S_WALK: begin
            if (walk_stop) begin
               // zero budget divides 0 by 1 so the share comes out 0
               div_start = 1'b1;
               div_num   = (budget_ff == '0) ? '0 : pct_num;
               div_den   = (budget_ff == '0) ? BUDGET_W'(1) : budget_ff;
            end else begin
               fill_re    = 1'b1;
               fill_raddr = cursor_ff[IXW-1:0];
            end
         end
         S_FILL: begin
            if (bucket_fits) fill_we = 1'b1;
            else div_start = 1'b1;
         end
         S_DIV: begin
            if (!div_busy) begin
               fill_we    = 1'b1;
               fill_wdata = cnt_ff - FW'(div_quo[BUDGET_W-1:0]);
            end
         end
         S_RD:   store_re = 1'b1;
         S_PICK: emit = out_free;
         S_PCT:  emit = !div_busy && out_free;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in       = clr_ff;
      budget_in    = budget_ff;
      selecting_in = selecting_ff;
      cursor_in    = cursor_ff;
      space_in     = space_ff;
      take_in      = take_ff;
      whole_in     = whole_ff;
      rpos_in      = rpos_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      acc_in       = acc_ff;
      phandle_in   = phandle_ff;
      plen_in      = plen_ff;
      pct_in       = pct_ff;
      widen_in     = widen_ff;
      tight_in     = tight_ff;
      if (csr_wr_en && !selecting_ff) budget_in = csr_wr_data;
      if (emit) begin
         rsp_valid_in = 1'b1;
         acc_in       = 1'b0;
         phandle_in   = '0;
         plen_in      = '0;
         pct_in       = '0;
         widen_in     = 1'b0;
         tight_in     = 1'b0;
      end
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + 1'b1;
         S_IDLE: begin
            // a pull outside a round opens one with the full budget
            if (accept && req_action && !selecting_ff) begin
               selecting_in = 1'b1;
               space_in     = budget_ff;
               cursor_in    = '0;
               take_in      = '0;
               whole_in     = 1'b0;
               rpos_in      = '0;
            end
         end
         S_OFF_CHK: begin
            if (emit) begin
               kind_in = KIND_OFFER;
               acc_in  = off_ok;
            end
         end
         S_WALK: if (!walk_stop) cursor_in = cursor_ff + 1'b1;
         S_FILL: begin
            cnt_in = fill_rd_ff;
            if (bucket_fits) begin
               // whole bucket goes out oldest first
               take_in  = fill_rd_ff;
               whole_in = 1'b1;
               space_in = space_ff - BUDGET_W'(bucket_lits);
               rpos_in  = '0;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               // partial bucket: newest clauses first
               take_in  = FW'(div_quo[BUDGET_W-1:0]);
               whole_in = 1'b0;
               space_in = space_ff - BUDGET_W'(part_lits);
               rpos_in  = cnt_ff - 1'b1;
            end
         end
         S_PICK: begin
            if (emit) begin
               kind_in    = KIND_PICK;
               phandle_in = store_rd_ff;
               plen_in    = cur_wide[PICK_LEN_W-1:0];
               take_in    = take_ff - 1'b1;
               rpos_in    = whole_ff ? rpos_ff + 1'b1 : rpos_ff - 1'b1;
            end
         end
         S_PCT: begin
            if (emit) begin
               kind_in      = KIND_DONE;
               pct_in       = pct_q;
               widen_in     = pct_q < PCT_W'(WIDEN_BELOW);
               tight_in     = pct_q > PCT_W'(TIGHTEN_ABOVE);
               selecting_in = 1'b0;
               whole_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         budget_ff    <= BUDGET_W'(RESET_BUDGET);
         selecting_ff <= 1'b0;
         cursor_ff    <= '0;
         space_ff     <= '0;
         take_ff      <= '0;
         whole_ff     <= 1'b0;
         rpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         budget_ff    <= budget_in;
         selecting_ff <= selecting_in;
         cursor_ff    <= cursor_in;
         space_ff     <= space_in;
         take_ff      <= take_in;
         whole_ff     <= whole_in;
         rpos_ff      <= rpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff     <= cnt_in;
      kind_ff    <= kind_in;
      acc_ff     <= acc_in;
      phandle_ff <= phandle_in;
      plen_ff    <= plen_in;
      pct_ff     <= pct_in;
      widen_ff   <= widen_in;
      tight_ff   <= tight_in;
      if (accept) begin
         act_ff    <= req_action;
         handle_ff <= req_clause_handle;
         len_ff    <= req_clause_len;
         off_ok_ff <= !selecting_ff && (req_clause_len != '0) &&
                      (req_clause_len <= LEN_W'(MAX_SIZE));
      end
   end

   // fill counts
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
      if (fill_re) fill_rd_ff <= fill_mem[fill_raddr];
   end

   // clause handles
   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= handle_ff;
      if (store_re) store_rd_ff <= store_mem[store_raddr];
   end

   bcs_div #(
      .NW(NUM_W),
      .DW(BUDGET_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .quo(div_quo)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_picked_handle = phandle_ff;
   assign rsp_picked_len    = plen_ff;
   assign rsp_percent_used  = pct_ff;
   assign rsp_widen_limit   = widen_ff;
   assign rsp_tighten_limit = tight_ff;

`ifndef SYNTHESIS
   a_pending_needs_round: assert property (@(posedge clock) disable iff (reset)
      (take_ff != '0) |-> selecting_ff)
      else $error("clauses pending outside a round");
   a_space_in_budget: assert property (@(posedge clock) disable iff (reset)
      selecting_ff |-> (space_ff <= budget_ff))
      else $error("allowance exceeds budget");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted word started no work");
   a_offer_word: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == S_OFF_CHK) |-> !act_ff)
      else $error("offer response for a pull");
`endif
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
   import bcs_pkg::*;
();

   typedef struct {
      bcs_kind_type                   kind;
      logic                           accepted;
      logic [HANDLE_W-1:0]            handle;
      logic [PICK_LEN_W-1:0]          len;
      logic [PCT_W-1:0]               pct;
      logic                           widen;
      logic                           tighten;
   } rsp_word_type;

   // scoreboard: tracks the bucket state of the selector and predicts each response word
   class clause_scoreboard;
      logic [HANDLE_W-1:0] store [DEF_MAX_SIZE][DEF_BUCKET_DEPTH];
      int unsigned fill [DEF_MAX_SIZE];
      int unsigned budget;
      bit          selecting;
      int unsigned cursor, space, take_left, read_pos;
      bit          take_whole;
      rsp_word_type pending_q [$];
      int          errors;

      function new();
         budget = RESET_BUDGET;
         foreach (fill[i]) fill[i] = 0;
         selecting = 0;
         errors = 0;
      endfunction

      function void write_budget(logic [BUDGET_W-1:0] v);
         if (!selecting) budget = v;
      endfunction

      function void note_word(logic act, logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] l);
         rsp_word_type r;
         int unsigned  allow, cnt, pct, f;
         r = '{KIND_OFFER, 0, 0, 0, 0, 0, 0};
         if (act == 1'b0) begin
            if (!selecting && l >= 1 && l <= DEF_MAX_SIZE) begin
               f = fill[l-1];
               if (f < DEF_BUCKET_DEPTH && l * (f + 1) <= budget) begin
                  store[l-1][f] = h;
                  fill[l-1] = f + 1;
                  r.accepted = 1'b1;
               end
            end
            pending_q.push_back(r);
            return;
         end
         if (!selecting) begin
            selecting = 1;
            space = budget;
            cursor = 0;
            take_left = 0;
            take_whole = 0;
            read_pos = 0;
         end
         while (take_left == 0) begin
            // round over once the allowance cannot cover one more clause
            if (cursor >= DEF_MAX_SIZE || space / (cursor + 1) == 0) begin
               pct = 0;
               if (budget != 0 && space <= budget) pct = (budget - space) * PCT_SCALE / budget;
               selecting = 0;
               take_whole = 0;
               r.kind = KIND_DONE;
               r.pct = PCT_W'(pct);
               r.widen = pct < WIDEN_BELOW;
               r.tighten = pct > TIGHTEN_ABOVE;
               pending_q.push_back(r);
               return;
            end
            cursor++;
            allow = space / cursor;
            cnt = fill[cursor-1];
            if (allow >= cnt) begin
               // whole bucket, oldest first
               take_left = cnt;
               take_whole = 1;
               space -= cnt * cursor;
               read_pos = 0;
               fill[cursor-1] = 0;
            end else begin
               // partial bucket, newest first
               take_left = allow;
               take_whole = 0;
               space -= allow * cursor;
               read_pos = cnt - 1;
               fill[cursor-1] = cnt - allow;
            end
         end
         r.kind = KIND_PICK;
         r.handle = store[cursor-1][read_pos % DEF_BUCKET_DEPTH];
         r.len = PICK_LEN_W'(cursor);
         take_left--;
         if (take_whole) read_pos++;
         else read_pos--;
         pending_q.push_back(r);
      endfunction

      function void cmp(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            $error("%s expected %0d actual %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type e;
         if (pending_q.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         e = pending_q.pop_front();
         cmp("kind", e.kind, got.kind);
         cmp("accepted", e.accepted, got.accepted);
         cmp("picked_handle", e.handle, got.handle);
         cmp("picked_len", e.len, got.len);
         cmp("percent_used", e.pct, got.pct);
         cmp("widen_limit", e.widen, got.widen);
         cmp("tighten_limit", e.tighten, got.tighten);
      endfunction
   endclass

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE_CYCLES = 60;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic                  req_action = 0;
   logic [HANDLE_W-1:0]   req_clause_handle = 0;
   logic [LEN_W-1:0]      req_clause_len = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [1:0]            rsp_kind;
   logic                  rsp_accepted;
   logic [HANDLE_W-1:0]   rsp_picked_handle;
   logic [PICK_LEN_W-1:0] rsp_picked_len;
   logic [PCT_W-1:0]      rsp_percent_used;
   logic                  rsp_widen_limit;
   logic                  rsp_tighten_limit;
   logic                  csr_wr_en = 0;
   logic [BUDGET_W-1:0]   csr_wr_data = 0;

   clause_scoreboard sb = new();
   int  cycles = 0;
   int  words_sent = 0;
   int  stall_left = 0;
   bit  quiet = 0;       // no idling on either side while set

   budgeted_clause_selector uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_clause_handle(req_clause_handle), .req_clause_len(req_clause_len),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_accepted(rsp_accepted), .rsp_picked_handle(rsp_picked_handle),
      .rsp_picked_len(rsp_picked_len), .rsp_percent_used(rsp_percent_used),
      .rsp_widen_limit(rsp_widen_limit), .rsp_tighten_limit(rsp_tighten_limit),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // wait draw for one word; zero through quiet stretches
   function automatic int gap_draw();
      if (quiet) return 0;
      return $urandom_range(0, 18);
   endfunction

   // hard stop on a hung block
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side: check each accepted word, then stall a random while
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = bcs_kind_type'(rsp_kind);
            got.accepted = rsp_accepted;
            got.handle = rsp_picked_handle;
            got.len = rsp_picked_len;
            got.pct = rsp_percent_used;
            got.widen = rsp_widen_limit;
            got.tighten = rsp_tighten_limit;
            sb.check_word(got);
            stall_left = gap_draw();
            rsp_stall <= (stall_left != 0);
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   // one word on the request channel; valid stays high into the next word when no gap
   task automatic send_word(logic act, logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] l);
      int gap;
      gap = gap_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_clause_handle <= h;
      req_clause_len <= l;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_word(act, h, l);
      words_sent++;
   endtask

   task automatic offer(logic [LEN_W-1:0] l);
      send_word(1'b0, $urandom, l);
   endtask

   task automatic pull();
      send_word(1'b1, $urandom, LEN_W'($urandom_range(0, 4095)));
   endtask

   // sender holds off until every expected word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_budget(logic [BUDGET_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_budget(v);
   endtask

   // pull until the round reports done, optionally with stray offers inside
   task automatic run_round(bit noisy);
      pull();
      while (sb.selecting) begin
         if (noisy && $urandom_range(0, 9) == 0) offer(LEN_W'($urandom_range(1, 64)));
         else pull();
      end
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LEN_W'($urandom_range(1, 8));
      if (r < 90) return LEN_W'($urandom_range(9, 64));
      if (r < 95) return '0;
      return LEN_W'($urandom_range(65, 4095));
   endfunction

   initial begin
      int n, choice;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, refused sizes, offer inside a round
      send_word(1'b0, 32'h0000_0000, 12'd1);
      send_word(1'b0, 32'hFFFF_FFFF, 12'd64);
      offer(12'd0);
      offer(12'd65);
      offer(12'd4095);
      offer(12'd2048);
      offer(12'd2);
      offer(12'd2);
      offer(12'd3);
      pull();
      offer(12'd5);             // refused while the round is open
      set_budget(12'd77);       // ignored while the round is open
      run_round(0);
      // zero budget ends the round at once
      set_budget(12'd0);
      offer(12'd1);
      run_round(0);
      // budget of one: second offer of size one no longer fits
      set_budget(12'd1);
      offer(12'd1);
      offer(12'd1);
      run_round(0);
      set_budget(12'd4095);
      send_word(1'b0, 32'hA5A5_5A5A, 12'd64);
      run_round(0);

      // random phases: budget, a batch of offers, then a round
      while (words_sent < 1050) begin
         quiet = ($urandom_range(0, 3) == 0);
         choice = $urandom_range(0, 6);
         case (choice)
            0: set_budget(12'd1);
            1: set_budget(12'd2048);
            2: set_budget(12'd4095);
            3: set_budget(BUDGET_W'($urandom_range(20, 200)));
            default: set_budget(BUDGET_W'($urandom_range(1, 4095)));
         endcase
         n = $urandom_range(5, 80);
         repeat (n) offer(pick_len());
         if ($urandom_range(0, 7) == 0) begin
            // broken round: stop partway, finish it later
            repeat ($urandom_range(1, 10)) pull();
            offer(pick_len());
            set_budget(BUDGET_W'($urandom_range(1, 4095)));
            if (sb.selecting) run_round(1);
         end else begin
            run_round(1);
         end
      end

      quiet = 0;
      drain();
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
